[src/i2cram_pkg.sv]
// Shared types, widths and codes of the I2C register access master.
package i2cram_pkg;

   // Field widths of the request and response transactions and of the configuration register index.
   localparam int unsigned ReqTypeWidth = 2;
   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned CountWidth   = 5;
   localparam int unsigned CsrIdxWidth  = 1;

   // Longest burst read, in bytes.
   localparam logic [CountWidth-1:0] MAX_BURST = 5'd16;

   // Reset values of the configuration registers.
   localparam logic [ByteWidth-1:0] HALF_PERIOD_RESET = 8'd5;
   localparam logic [ByteWidth-1:0] ACK_TIMEOUT_RESET = 8'd250;

   // Request codes.
   localparam logic [ReqTypeWidth-1:0] REQ_TICK  = 2'd0;
   localparam logic [ReqTypeWidth-1:0] REQ_WRITE = 2'd1;
   localparam logic [ReqTypeWidth-1:0] REQ_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CSR_HALF_PERIOD = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ACK_TIMEOUT = 1'd1;

   // One request transaction.
   typedef struct packed {
      logic [ReqTypeWidth-1:0] req_type;
      logic [ByteWidth-1:0]    device_addr;
      logic [ByteWidth-1:0]    reg_addr;
      logic [ByteWidth-1:0]    write_data;
      logic [CountWidth-1:0]   read_count;
      logic                    sda_sample;
   } req_payload_type;

   // One response transaction.
   typedef struct packed {
      logic                 scl_level;
      logic                 sda_level;
      logic                 sda_drive;
      logic                 busy_res;
      logic [ByteWidth-1:0] read_byte;
      logic                 read_valid;
      logic                 last;
      logic                 ack_error;
   } rsp_payload_type;

   // Configuration values handed to the sequencer.
   typedef struct packed {
      logic [ByteWidth-1:0] half_period_ticks;
      logic [ByteWidth-1:0] ack_timeout_ticks;
   } cfg_type;

endpackage

[src/i2cram_if.sv]
// Valid/ready channel interfaces for request and response transactions.
interface i2cram_req_if import i2cram_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [ReqTypeWidth-1:0] req_type;
   logic [ByteWidth-1:0]    device_addr;
   logic [ByteWidth-1:0]    reg_addr;
   logic [ByteWidth-1:0]    write_data;
   logic [CountWidth-1:0]   read_count;
   logic                    sda_sample;

   modport source (output valid, req_type, device_addr, reg_addr, write_data, read_count,
                   sda_sample, input ready);
   modport sink (input valid, req_type, device_addr, reg_addr, write_data, read_count,
                 sda_sample, output ready);
endinterface

interface i2cram_rsp_if import i2cram_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 scl_level;
   logic                 sda_level;
   logic                 sda_drive;
   logic                 busy_res;
   logic [ByteWidth-1:0] read_byte;
   logic                 read_valid;
   logic                 last;
   logic                 ack_error;

   modport source (output valid, scl_level, sda_level, sda_drive, busy_res, read_byte,
                   read_valid, last, ack_error, input ready);
   modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, read_byte,
                 read_valid, last, ack_error, output ready);
endinterface

[src/i2cram_seq.sv]
// Bus phase sequencer: holds transaction state and computes one tick per step.
module i2cram_seq import i2cram_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  req_payload_type req,
   input  cfg_type         cfg,
   output rsp_payload_type rsp
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST_HI, PH_ST_LO, PH_TX_LOW, PH_TX_HIGH, PH_AK_LOW, PH_AK_HIGH,
      PH_AK_POLL, PH_RS_LOW, PH_RX_LOW, PH_RX_HIGH, PH_MA_LOW, PH_MA_HIGH,
      PH_SP_A, PH_SP_B, PH_SP_C
   } phase_type;

   // Which byte of the address sequence is being sent.
   typedef enum logic [1:0] {
      SEQ_DEV, SEQ_REG, SEQ_DATA, SEQ_RDEV
   } seq_type;

   phase_type             phase_ff, phase_in;
   seq_type               seq_ff, seq_in;
   logic [ByteWidth-1:0]  tick_ff, tick_in;
   logic [3:0]            bit_ff, bit_in;
   logic [ByteWidth-1:0]  shift_ff, shift_in;
   logic [CountWidth-1:0] left_ff, left_in;
   logic [ByteWidth-1:0]  wait_ff, wait_in;
   logic [ByteWidth-1:0]  dev_ff, dev_in;
   logic [ByteWidth-1:0]  reg_ff, reg_in;
   logic [ByteWidth-1:0]  data_ff, data_in;
   logic                  is_read_ff, is_read_in;
   logic                  abort_ff, abort_in;

   logic                  start;
   logic                  end_phase;
   logic [ByteWidth-1:0]  hp;
   logic [CountWidth-1:0] count;
   logic [ByteWidth-1:0]  rx_byte;

   // A write or read request starts only on an idle bus.
   assign start = (phase_ff == PH_IDLE) &&
                  ((req.req_type == REQ_WRITE) || (req.req_type == REQ_READ));
   assign hp = (cfg.half_period_ticks == '0) ? 8'd1 : cfg.half_period_ticks;

   // Clamp the burst length into one to MAX_BURST.
   always_comb begin
      count = req.read_count;
      if (count == '0) begin
         count = 5'd1;
      end
      if (count > MAX_BURST) begin
         count = MAX_BURST;
      end
   end

   // Next state and response of one tick.
   always_comb begin
      phase_in   = phase_ff;
      seq_in     = seq_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      left_in    = left_ff;
      wait_in    = wait_ff;
      dev_in     = dev_ff;
      reg_in     = reg_ff;
      data_in    = data_ff;
      is_read_in = is_read_ff;
      abort_in   = abort_ff;
      end_phase  = 1'b0;
      rx_byte    = '0;
      rsp        = '0;
      rsp.scl_level = 1'b1;
      rsp.sda_level = 1'b1;
      rsp.sda_drive = 1'b1;

      // Latch a new request; the first start phase runs on this same tick.
      if (start) begin
         dev_in     = req.device_addr;
         reg_in     = req.reg_addr;
         data_in    = req.write_data;
         is_read_in = (req.req_type == REQ_READ);
         left_in    = count;
         seq_in     = SEQ_DEV;
         abort_in   = 1'b0;
         wait_in    = '0;
         tick_in    = '0;
         bit_in     = '0;
         shift_in   = '0;
         phase_in   = PH_ST_HI;
      end

      if (phase_in != PH_IDLE) begin
         rsp.busy_res = 1'b1;
         // Every phase but the acknowledge poll lasts hp ticks.
         if (phase_in != PH_AK_POLL) begin
            end_phase = ({1'b0, tick_in} + 9'd1) >= {1'b0, hp};
            tick_in   = end_phase ? '0 : tick_in + 8'd1;
         end
         case (phase_in)
            PH_ST_HI: begin
               if (end_phase) phase_in = PH_ST_LO;
            end
            PH_ST_LO: begin
               rsp.sda_level = 1'b0;
               if (end_phase) begin
                  shift_in = (seq_in == SEQ_RDEV) ? dev_in + 8'd1 : dev_in;
                  bit_in   = '0;
                  phase_in = PH_TX_LOW;
               end
            end
            PH_TX_LOW: begin
               rsp.scl_level = 1'b0;
               rsp.sda_level = shift_in[7];
               if (end_phase) phase_in = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
               rsp.sda_level = shift_in[7];
               if (end_phase) begin
                  shift_in = {shift_in[6:0], 1'b0};
                  bit_in   = bit_in + 4'd1;
                  phase_in = (bit_in >= 4'd8) ? PH_AK_LOW : PH_TX_LOW;
               end
            end
            PH_AK_LOW: begin
               rsp.scl_level = 1'b0;
               rsp.sda_drive = 1'b0;
               if (end_phase) begin
                  wait_in  = '0;
                  phase_in = PH_AK_HIGH;
               end
            end
            PH_AK_HIGH: begin
               rsp.sda_drive = 1'b0;
               if (end_phase) phase_in = PH_AK_POLL;
            end
            PH_AK_POLL: begin
               rsp.sda_drive = 1'b0;
               tick_in = '0;
               if (!req.sda_sample) begin
                  // Acknowledged: move on to the next byte of the sequence.
                  case (seq_in)
                     SEQ_DEV: begin
                        seq_in   = SEQ_REG;
                        shift_in = reg_in;
                        bit_in   = '0;
                        phase_in = PH_TX_LOW;
                     end
                     SEQ_REG: begin
                        if (is_read_in) begin
                           seq_in   = SEQ_RDEV;
                           phase_in = PH_RS_LOW;
                        end else begin
                           seq_in   = SEQ_DATA;
                           shift_in = data_in;
                           bit_in   = '0;
                           phase_in = PH_TX_LOW;
                        end
                     end
                     SEQ_DATA: begin
                        phase_in = PH_SP_A;
                     end
                     default: begin
                        shift_in = '0;
                        bit_in   = '0;
                        phase_in = PH_RX_LOW;
                     end
                  endcase
               end else if (wait_in >= cfg.ack_timeout_ticks) begin
                  abort_in = 1'b1;
                  phase_in = PH_SP_A;
               end else begin
                  wait_in = wait_in + 8'd1;
               end
            end
            PH_RS_LOW: begin
               rsp.scl_level = 1'b0;
               if (end_phase) phase_in = PH_ST_HI;
            end
            PH_RX_LOW: begin
               rsp.scl_level = 1'b0;
               rsp.sda_drive = 1'b0;
               if (end_phase) phase_in = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
               rsp.sda_drive = 1'b0;
               if (end_phase) begin
                  rx_byte  = {shift_in[6:0], req.sda_sample};
                  shift_in = rx_byte;
                  bit_in   = bit_in + 4'd1;
                  if (bit_in >= 4'd8) begin
                     rsp.read_byte  = rx_byte;
                     rsp.read_valid = 1'b1;
                     if (left_in != '0) begin
                        left_in = left_in - 5'd1;
                     end
                     phase_in = PH_MA_LOW;
                  end else begin
                     phase_in = PH_RX_LOW;
                  end
               end
            end
            PH_MA_LOW: begin
               // ACK every byte but the last, which gets NACK.
               rsp.scl_level = 1'b0;
               rsp.sda_level = (left_in == '0);
               if (end_phase) phase_in = PH_MA_HIGH;
            end
            PH_MA_HIGH: begin
               rsp.sda_level = (left_in == '0);
               if (end_phase) begin
                  if (left_in != '0) begin
                     shift_in = '0;
                     bit_in   = '0;
                     phase_in = PH_RX_LOW;
                  end else begin
                     phase_in = PH_SP_A;
                  end
               end
            end
            PH_SP_A: begin
               rsp.scl_level = 1'b0;
               rsp.sda_level = 1'b0;
               if (end_phase) phase_in = PH_SP_B;
            end
            PH_SP_B: begin
               rsp.sda_level = 1'b0;
               if (end_phase) phase_in = PH_SP_C;
            end
            default: begin
               // Final stop phase: SDA rises while SCL is high.
               if (end_phase) begin
                  rsp.last      = 1'b1;
                  rsp.ack_error = abort_in;
                  abort_in      = 1'b0;
                  seq_in        = SEQ_DEV;
                  phase_in      = PH_IDLE;
               end
            end
         endcase
      end
   end

   // State registers advance once per processed tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         seq_ff     <= SEQ_DEV;
         tick_ff    <= '0;
         bit_ff     <= '0;
         shift_ff   <= '0;
         left_ff    <= '0;
         wait_ff    <= '0;
         dev_ff     <= '0;
         reg_ff     <= '0;
         data_ff    <= '0;
         is_read_ff <= 1'b0;
         abort_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         seq_ff     <= seq_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         left_ff    <= left_in;
         wait_ff    <= wait_in;
         dev_ff     <= dev_in;
         reg_ff     <= reg_in;
         data_ff    <= data_in;
         is_read_ff <= is_read_in;
         abort_ff   <= abort_in;
      end
   end

endmodule

[src/i2c_register_access_master_core.sv]
// I2C register access master: input register, tick sequencer and response register.
// A request is registered in the input register, and its response transaction is then
// registered in the response register, where it stays valid until it is taken.
// One tick transaction per cycle while the response register is not stalled.
// While a response stalls, a request is accepted only if the input register is empty.
// Reset (synchronous, active high) empties both registers, idles the bus sequencer and
// loads half_period_ticks with 5 and ack_timeout_ticks with 250.
module i2c_register_access_master_core import i2cram_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   i2cram_req_if.sink             req_if,
   i2cram_rsp_if.source           rsp_if,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ByteWidth-1:0]   csr_wdata
);

   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   logic [ByteWidth-1:0] half_ff;
   logic [ByteWidth-1:0] timeout_ff;

   logic            out_adv;
   logic            step_en;
   cfg_type         cfg;
   rsp_payload_type step_rsp;

   // Pipeline flow control.
   assign out_adv      = !out_valid_ff || rsp_if.ready;
   assign step_en      = in_valid_ff && out_adv;
   assign req_if.ready = !in_valid_ff || out_adv;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff    <= HALF_PERIOD_RESET;
         timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HALF_PERIOD: half_ff    <= csr_wdata;
            CSR_ACK_TIMEOUT: timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.half_period_ticks = half_ff;
   assign cfg.ack_timeout_ticks = timeout_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_if.valid && req_if.ready) begin
         in_data_ff.req_type    <= req_if.req_type;
         in_data_ff.device_addr <= req_if.device_addr;
         in_data_ff.reg_addr    <= req_if.reg_addr;
         in_data_ff.write_data  <= req_if.write_data;
         in_data_ff.read_count  <= req_if.read_count;
         in_data_ff.sda_sample  <= req_if.sda_sample;
      end
   end

   i2cram_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= in_valid_ff;
      end
      if (step_en) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.scl_level  = out_data_ff.scl_level;
   assign rsp_if.sda_level  = out_data_ff.sda_level;
   assign rsp_if.sda_drive  = out_data_ff.sda_drive;
   assign rsp_if.busy_res   = out_data_ff.busy_res;
   assign rsp_if.read_byte  = out_data_ff.read_byte;
   assign rsp_if.read_valid = out_data_ff.read_valid;
   assign rsp_if.last       = out_data_ff.last;
   assign rsp_if.ack_error  = out_data_ff.ack_error;

endmodule

[src/i2cram_checker.sv]
// Port-level checks of the I2C register access master and their binding to the top level.
module i2cram_checker import i2cram_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 scl_level,
   input logic                 sda_level,
   input logic                 sda_drive,
   input logic                 busy_res,
   input logic [ByteWidth-1:0] read_byte,
   input logic                 read_valid,
   input logic                 last,
   input logic                 ack_error
);

   // A stalled response transaction keeps its read byte and last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_byte) && $stable(last))
      else $error("stalled response changed");

   // An abort is only reported on the closing tick of a transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ack_error |-> last && busy_res)
      else $error("ack_error without last");

   // The closing tick leaves both bus lines high and driven.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last |-> scl_level && sda_level && sda_drive)
      else $error("stop condition not completed on last");

   // A received byte completes on a high SCL phase with SDA released.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && read_valid |-> busy_res && scl_level && !sda_drive)
      else $error("read byte outside a receive phase");

   // Without a transaction the bus idles high with no data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !busy_res |-> scl_level && sda_level && !read_valid && !last)
      else $error("idle bus not quiet");

endmodule

bind i2c_register_access_master_core i2cram_checker u_i2cram_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .scl_level  (rsp_if.scl_level),
   .sda_level  (rsp_if.sda_level),
   .sda_drive  (rsp_if.sda_drive),
   .busy_res   (rsp_if.busy_res),
   .read_byte  (rsp_if.read_byte),
   .read_valid (rsp_if.read_valid),
   .last       (rsp_if.last),
   .ack_error  (rsp_if.ack_error)
);
